// ----- src/sfrh_pkg.sv -----
// Shared types and constants for the screen fade ramp controller.
package sfrh_pkg;

    localparam int LEVEL_W  = 16;
    localparam int CFG_W    = 15;
    localparam int COLOUR_W = 32;
    localparam int ALPHA_W  = 8;
    localparam int ALPHA_SH = 5;

    localparam logic [CFG_W-1:0] FULL_LEVEL_RESET = 15'h1FE0;
    localparam logic [CFG_W-1:0] HOLD_TICKS_RESET = 15'd30;

    // Register index, taken from byte address bit 2.
    localparam logic REG_FULL_LEVEL = 1'b0;
    localparam logic REG_HOLD_TICKS = 1'b1;

    typedef enum logic [1:0] {
        FUNC_ARM      = 2'd0,
        FUNC_STEP_OUT = 2'd1,
        FUNC_STEP_IN  = 2'd2,
        FUNC_SET      = 2'd3
    } func_t;

endpackage

// ----- src/screen_fade_ramp_with_hold.sv -----
// Screen fade controller: fade-out and fade-in ramps driving one overlay.
// An accepted item sits in the input register, and the result register is loaded from the
// ramp logic once the result register can advance (it is empty or m_tready is high).
// Throughput: one item per cycle unless m_tready is low; there is a single 16x16 multiply-add.
// Reset clears all channel state, the overlay and the handshake; the
// configuration registers return to level 0x1FE0 and a hold of 30 ticks.
module screen_fade_ramp_with_hold
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // speed[15:0], colour[47:16], frame_ticks[63:48], alpha[71:64]
    input  logic [2:0]  s_tuser,   // func[1:0], fade_out[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // overlay_colour[31:0], overlay_alpha[39:32]
    output logic [0:0]  m_tuser,   // done_res[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [sfrh_pkg::CFG_W-1:0] full_reg;
    logic [sfrh_pkg::CFG_W-1:0] hold_cfg_reg;

    // Input register
    logic                          st_valid_reg;
    sfrh_pkg::func_t               st_func_reg;
    logic                          st_fo_reg;
    logic [sfrh_pkg::LEVEL_W-1:0]  st_speed_reg;
    logic [sfrh_pkg::COLOUR_W-1:0] st_colour_reg;
    logic [sfrh_pkg::LEVEL_W-1:0]  st_ticks_reg;
    logic [sfrh_pkg::ALPHA_W-1:0]  st_alpha_reg;

    // Channel state
    logic [sfrh_pkg::LEVEL_W-1:0]  in_level_reg,  in_level_next;
    logic [sfrh_pkg::LEVEL_W-1:0]  in_speed_reg,  in_speed_next;
    logic [sfrh_pkg::COLOUR_W-1:0] in_colour_reg, in_colour_next;
    logic [sfrh_pkg::LEVEL_W-1:0]  out_level_reg,  out_level_next;
    logic [sfrh_pkg::LEVEL_W-1:0]  out_hold_reg,   out_hold_next;
    logic [sfrh_pkg::LEVEL_W-1:0]  out_speed_reg,  out_speed_next;
    logic [sfrh_pkg::COLOUR_W-1:0] out_colour_reg, out_colour_next;

    // Result register; its payload is also the shown overlay state.
    logic                          m_valid_reg;
    logic [sfrh_pkg::COLOUR_W-1:0] shown_colour_reg, shown_colour_next;
    logic [sfrh_pkg::ALPHA_W-1:0]  shown_alpha_reg,  shown_alpha_next;
    logic                          done_reg, done_next;

    logic                          advance;
    logic                          fire;
    logic                          cfg_wr;
    logic [sfrh_pkg::LEVEL_W-1:0]  mul_speed;
    logic [sfrh_pkg::LEVEL_W-1:0]  delta;
    logic [sfrh_pkg::LEVEL_W-1:0]  sum_out;
    logic [sfrh_pkg::LEVEL_W-1:0]  diff_in;
    logic signed [sfrh_pkg::LEVEL_W-1:0] full_s;
    logic [sfrh_pkg::LEVEL_W-1:0]  full_ext;
    logic [sfrh_pkg::LEVEL_W-1:0]  alpha_level;

    assign advance  = !m_valid_reg || m_tready;
    assign fire     = st_valid_reg && advance;
    assign s_tready = !st_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {shown_alpha_reg, shown_colour_reg};
    assign m_tuser  = done_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == sfrh_pkg::REG_HOLD_TICKS)
                    ? {17'd0, hold_cfg_reg} : {17'd0, full_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg     <= sfrh_pkg::FULL_LEVEL_RESET;
            hold_cfg_reg <= sfrh_pkg::HOLD_TICKS_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == sfrh_pkg::REG_HOLD_TICKS)
                hold_cfg_reg <= pwdata[sfrh_pkg::CFG_W-1:0];
            else
                full_reg <= pwdata[sfrh_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else if (s_tready)
            st_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            st_func_reg   <= sfrh_pkg::func_t'(s_tuser[1:0]);
            st_fo_reg     <= s_tuser[2];
            st_speed_reg  <= s_tdata[15:0];
            st_colour_reg <= s_tdata[47:16];
            st_ticks_reg  <= s_tdata[63:48];
            st_alpha_reg  <= s_tdata[71:64];
        end
    end

    // One shared multiplier; only the low 16 bits of the product matter.
    assign mul_speed = (st_func_reg == sfrh_pkg::FUNC_STEP_OUT) ? out_speed_reg : in_speed_reg;
    assign delta     = sfrh_pkg::LEVEL_W'(mul_speed * st_ticks_reg);
    assign sum_out   = out_level_reg + delta;
    assign diff_in   = in_level_reg - delta;
    assign full_ext  = {1'b0, full_reg};
    assign full_s    = $signed(full_ext);

    always_comb
    begin
        in_level_next     = in_level_reg;
        in_speed_next     = in_speed_reg;
        in_colour_next    = in_colour_reg;
        out_level_next    = out_level_reg;
        out_hold_next     = out_hold_reg;
        out_speed_next    = out_speed_reg;
        out_colour_next   = out_colour_reg;
        shown_colour_next = shown_colour_reg;
        alpha_level       = '0;
        done_next         = 1'b0;

        case (st_func_reg)
            sfrh_pkg::FUNC_ARM:
            begin
                if (st_fo_reg)
                begin
                    out_level_next    = '0;
                    out_hold_next     = {1'b0, hold_cfg_reg};
                    out_speed_next    = st_speed_reg;
                    out_colour_next   = st_colour_reg;
                    alpha_level       = '0;
                end
                else
                begin
                    in_level_next     = full_ext;
                    in_speed_next     = st_speed_reg;
                    in_colour_next    = st_colour_reg;
                    alpha_level       = full_ext;
                end
                shown_colour_next = st_colour_reg;
            end
            sfrh_pkg::FUNC_STEP_OUT:
            begin
                if ($signed(out_level_reg) < full_s)
                begin
                    // A wrap to a negative level is left alone; only overshoot clamps.
                    if ($signed(sum_out) > full_s)
                        out_level_next = full_ext;
                    else
                        out_level_next = sum_out;
                end
                else if ($signed(out_hold_reg) < $signed(16'sd1))
                    done_next = 1'b1;
                else
                    out_hold_next = out_hold_reg - st_ticks_reg;
                alpha_level       = out_level_next;
                shown_colour_next = out_colour_reg;
            end
            sfrh_pkg::FUNC_STEP_IN:
            begin
                if (diff_in[sfrh_pkg::LEVEL_W-1])
                begin
                    in_level_next = '0;
                    done_next     = 1'b1;
                end
                else
                    in_level_next = diff_in;
                alpha_level       = in_level_next;
                shown_colour_next = in_colour_reg;
            end
            default:
            begin
                shown_colour_next = st_colour_reg;
            end
        endcase

        if (st_func_reg == sfrh_pkg::FUNC_SET)
            shown_alpha_next = st_alpha_reg;
        else
            shown_alpha_next = alpha_level[sfrh_pkg::ALPHA_SH +: sfrh_pkg::ALPHA_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_level_reg     <= '0;
            in_speed_reg     <= '0;
            in_colour_reg    <= '0;
            out_level_reg    <= '0;
            out_hold_reg     <= '0;
            out_speed_reg    <= '0;
            out_colour_reg   <= '0;
            shown_colour_reg <= '0;
            shown_alpha_reg  <= '0;
            done_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            if (advance)
                m_valid_reg <= st_valid_reg;
            if (fire)
            begin
                in_level_reg     <= in_level_next;
                in_speed_reg     <= in_speed_next;
                in_colour_reg    <= in_colour_next;
                out_level_reg    <= out_level_next;
                out_hold_reg     <= out_hold_next;
                out_speed_reg    <= out_speed_next;
                out_colour_reg   <= out_colour_next;
                shown_colour_reg <= shown_colour_next;
                shown_alpha_reg  <= shown_alpha_next;
                done_reg         <= done_next;
            end
        end
    end

    // The fade-in level is never left negative.
    a_in_level_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !in_level_reg[sfrh_pkg::LEVEL_W-1])
        else $error("fade-in level holds a negative value");

    // With the result register empty the block must take an item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_tready)
        else $error("input stalled while the result register is empty");

    // An item leaving the input register always shows up as a result.
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_valid_reg)
        else $error("item lost between input and result register");

endmodule
